// ----- rtl/core/isd_pkg.sv -----
package isd_pkg;

    // Action codes
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_ONESHOT = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_STATUS  = 3'd4;

    // Field widths
    localparam int DWELL_W = 13;
    localparam int DVD_W   = 30;    // advance_q4 * 1e6 fits in 30 bits
    localparam int DVS_W   = 23;    // 96 * rpm fits in 23 bits

    // Spark arithmetic
    localparam logic [19:0] ADV_SCALE    = 20'd1000000;
    localparam int          START_MARGIN = 10;

    // Dwell selection, battery thresholds in mV
    localparam logic [15:0] MV_LOW  = 16'd11000;
    localparam logic [15:0] MV_MID  = 16'd12500;
    localparam logic [15:0] MV_HIGH = 16'd14000;
    localparam logic [15:0] RPM_HI  = 16'd8000;
    localparam logic [15:0] RPM_LO  = 16'd1000;

    // Dwell values in us: nominal, high speed (x17/20), low speed (x23/20)
    localparam logic [DWELL_W-1:0] DW_NOM_0 = 13'd4500;
    localparam logic [DWELL_W-1:0] DW_NOM_1 = 13'd3500;
    localparam logic [DWELL_W-1:0] DW_NOM_2 = 13'd3000;
    localparam logic [DWELL_W-1:0] DW_NOM_3 = 13'd2800;
    localparam logic [DWELL_W-1:0] DW_HI_0  = 13'd3825;
    localparam logic [DWELL_W-1:0] DW_HI_1  = 13'd2975;
    localparam logic [DWELL_W-1:0] DW_HI_2  = 13'd2550;
    localparam logic [DWELL_W-1:0] DW_HI_3  = 13'd2380;
    localparam logic [DWELL_W-1:0] DW_LO_0  = 13'd5175;
    localparam logic [DWELL_W-1:0] DW_LO_1  = 13'd4025;
    localparam logic [DWELL_W-1:0] DW_LO_2  = 13'd3450;
    localparam logic [DWELL_W-1:0] DW_LO_3  = 13'd3220;
    localparam logic [DWELL_W-1:0] DW_RESET = 13'd3000;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  cylinder;
        logic [15:0] engine_rpm;
        logic [9:0]  advance_q4;
        logic [15:0] spark_delay;
        logic [15:0] battery_mv;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        logic [3:0]         coil_levels;
        logic [3:0]         active_mask;
        logic [DWELL_W-1:0] dwell_us;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_EXEC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic mul;
        logic div_load;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_busy;
    } t_stat;

    // Dwell from battery voltage, scaled for engine speed
    function automatic logic [DWELL_W-1:0] pick_dwell(input logic [15:0] mv,
                                                      input logic [15:0] rpm);
        logic [1:0] band;
        logic [DWELL_W-1:0] dw;
        if (mv < MV_LOW) begin
            band = 2'd0;
        end else if (mv < MV_MID) begin
            band = 2'd1;
        end else if (mv < MV_HIGH) begin
            band = 2'd2;
        end else begin
            band = 2'd3;
        end
        if (rpm > RPM_HI) begin
            case (band)
                2'd0:    dw = DW_HI_0;
                2'd1:    dw = DW_HI_1;
                2'd2:    dw = DW_HI_2;
                default: dw = DW_HI_3;
            endcase
        end else if (rpm < RPM_LO) begin
            case (band)
                2'd0:    dw = DW_LO_0;
                2'd1:    dw = DW_LO_1;
                2'd2:    dw = DW_LO_2;
                default: dw = DW_LO_3;
            endcase
        end else begin
            case (band)
                2'd0:    dw = DW_NOM_0;
                2'd1:    dw = DW_NOM_1;
                2'd2:    dw = DW_NOM_2;
                default: dw = DW_NOM_3;
            endcase
        end
        return dw;
    endfunction

endpackage

// ----- rtl/core/isd_div.sv -----
module isd_div #(
    parameter int DIVIDEND_W = 30,
    parameter int DIVISOR_W  = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    // Control: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/isd_ctrl.sv -----
module isd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  isd_pkg::t_stat i_stat,
    output isd_pkg::t_cmd  o_cmd
);
    import isd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.need_div ? ST_MUL : ST_EXEC;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // commit only when the output register can take the beat
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/isd_dp.sv -----
module isd_dp #(
    parameter int CHANNELS     = 4,
    parameter int COUNTER_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isd_pkg::t_in_item i_in_data,
    input  isd_pkg::t_cmd     i_cmd,
    output isd_pkg::t_stat    o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output isd_pkg::t_out_item o_out_data
);
    import isd_pkg::*;

    localparam int CB    = COUNTER_BITS;
    localparam int CMP_W = ((DVD_W > CB) ? DVD_W : CB) + 1;
    localparam int PAD_W = (CHANNELS > 4) ? CHANNELS : 4;
    localparam logic [CMP_W-1:0] PERIOD_MAX = CMP_W'((64'd1 << CB) - 64'd1);

    // Latched command and arithmetic operands
    t_in_item           r_item;
    logic [DVD_W-1:0]   r_dvd;
    logic [DVS_W-1:0]   r_dvs;
    logic               div_busy;
    logic [DVD_W-1:0]   quo;

    // Channel state
    logic [CB-1:0]      r_cnt   [CHANNELS];
    logic [CB-1:0]      r_per   [CHANNELS];
    logic [CB-1:0]      r_ds    [CHANNELS];
    logic [CB-1:0]      r_spk   [CHANNELS];
    logic [DWELL_W-1:0] r_dwell [CHANNELS];
    logic [CHANNELS-1:0] r_run, r_act, r_lvl;

    logic [CB-1:0]      n_cnt   [CHANNELS];
    logic [CB-1:0]      n_per   [CHANNELS];
    logic [CB-1:0]      n_ds    [CHANNELS];
    logic [CB-1:0]      n_spk   [CHANNELS];
    logic [DWELL_W-1:0] n_dwell [CHANNELS];
    logic [CHANNELS-1:0] n_run, n_act, n_lvl;

    // Tick lanes
    logic [CB-1:0]      cnt_inc [CHANNELS];
    logic [CHANNELS-1:0] tick_last, tick_lvl;

    // Output register
    logic               r_out_valid;
    t_out_item          r_out;

    // Decode
    logic [3:0]          cyl_m1;
    logic                cyl_ok;
    logic                in_cyl_ok;
    logic [CHANNELS-1:0] sel;
    logic                rpm_ok;
    logic [DWELL_W-1:0]  dwell_ld;
    logic [CMP_W-1:0]    start_per;
    logic [CMP_W-1:0]    shot_per;
    logic                start_fit, shot_fit;
    logic [CB-1:0]       spk_ld, per_ld, ds_ld;
    logic                load, ok;
    logic [DWELL_W-1:0]  dw_out;
    logic [PAD_W-1:0]    lvl_pad, act_pad;

    // Start needs the divider only when it can be accepted at all
    always_comb begin
        in_cyl_ok = (i_in_data.cylinder != 3'd0) &&
                    (5'(i_in_data.cylinder) <= 5'(CHANNELS));
        o_stat.need_div = (i_in_data.action == ACT_START) && in_cyl_ok &&
                          (i_in_data.engine_rpm != 16'd0);
        o_stat.div_busy = div_busy;
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    // Command capture and operand stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mul) begin
            r_dvd <= DVD_W'(r_item.advance_q4) * DVD_W'(ADV_SCALE);
            r_dvs <= (DVS_W'(r_item.engine_rpm) << 6) + (DVS_W'(r_item.engine_rpm) << 5);
        end
    end

    isd_div #(
        .DIVIDEND_W (DVD_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_cmd.div_load),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // Per-channel tick: advance, stop at period - 1, recompute the coil
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            cnt_inc[i]   = r_cnt[i] + 1'b1;
            tick_last[i] = ((CB + 1)'(cnt_inc[i]) + 1'b1) >= (CB + 1)'(r_per[i]);
            tick_lvl[i]  = (cnt_inc[i] >= r_ds[i]) && (cnt_inc[i] < r_spk[i]);
        end
    end

    // Channel address decode and load values
    always_comb begin
        cyl_m1 = 4'(r_item.cylinder) - 4'd1;
        cyl_ok = (r_item.cylinder != 3'd0) && (5'(r_item.cylinder) <= 5'(CHANNELS));
        for (int i = 0; i < CHANNELS; i++) begin
            sel[i] = cyl_ok && (cyl_m1 == 4'(i));
        end
        rpm_ok    = r_item.engine_rpm != 16'd0;
        dwell_ld  = pick_dwell(r_item.battery_mv, r_item.engine_rpm);
        start_per = CMP_W'(quo) + CMP_W'(START_MARGIN);
        shot_per  = CMP_W'(r_item.spark_delay) + CMP_W'(1);
        start_fit = (quo != '0) && (start_per <= PERIOD_MAX);
        shot_fit  = shot_per <= PERIOD_MAX;
        if (r_item.action == ACT_START) begin
            spk_ld = CB'(quo);
            per_ld = CB'(start_per);
        end else begin
            spk_ld = CB'(r_item.spark_delay);
            per_ld = CB'(shot_per);
        end
        ds_ld = (spk_ld > CB'(dwell_ld)) ? (spk_ld - CB'(dwell_ld)) : '0;
    end

    // Next channel state for the current command
    always_comb begin
        n_cnt   = r_cnt;
        n_per   = r_per;
        n_ds    = r_ds;
        n_spk   = r_spk;
        n_dwell = r_dwell;
        n_run   = r_run;
        n_act   = r_act;
        n_lvl   = r_lvl;
        load    = 1'b0;
        ok      = 1'b0;
        case (r_item.action)
            ACT_TICK: begin
                ok = 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_run[i]) begin
                        n_cnt[i] = cnt_inc[i];
                        n_lvl[i] = tick_lvl[i];
                        if (tick_last[i]) begin
                            n_run[i] = 1'b0;
                        end
                    end
                end
            end
            ACT_START: begin
                load = cyl_ok && rpm_ok && start_fit;
                ok   = load;
            end
            ACT_ONESHOT: begin
                load = cyl_ok && rpm_ok && shot_fit;
                ok   = load;
            end
            ACT_STOP: begin
                ok = cyl_ok;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (sel[i]) begin
                        n_run[i] = 1'b0;
                        n_cnt[i] = '0;
                        n_lvl[i] = 1'b0;
                        n_act[i] = 1'b0;
                    end
                end
            end
            ACT_STATUS: begin
                ok = cyl_ok;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // load restarts the channel from count 0
        for (int i = 0; i < CHANNELS; i++) begin
            if (load && sel[i]) begin
                n_spk[i]   = spk_ld;
                n_ds[i]    = ds_ld;
                n_per[i]   = per_ld;
                n_cnt[i]   = '0;
                n_run[i]   = per_ld > CB'(1);
                n_act[i]   = 1'b1;
                n_dwell[i] = dwell_ld;
                n_lvl[i]   = (ds_ld == '0) && (spk_ld != '0);
            end
        end
    end

    // Result fields from the updated state
    always_comb begin
        dw_out = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (sel[i]) begin
                dw_out = n_dwell[i];
            end
        end
        lvl_pad = PAD_W'(n_lvl);
        act_pad = PAD_W'(n_act);
    end

    // Channel state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i]   <= '0;
                r_per[i]   <= '0;
                r_ds[i]    <= '0;
                r_spk[i]   <= '0;
                r_dwell[i] <= DW_RESET;
            end
            r_run <= '0;
            r_act <= '0;
            r_lvl <= '0;
        end else if (i_cmd.commit) begin
            r_cnt   <= n_cnt;
            r_per   <= n_per;
            r_ds    <= n_ds;
            r_spk   <= n_spk;
            r_dwell <= n_dwell;
            r_run   <= n_run;
            r_act   <= n_act;
            r_lvl   <= n_lvl;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.ok          <= ok;
            r_out.coil_levels <= lvl_pad[3:0];
            r_out.active_mask <= act_pad[3:0];
            r_out.dwell_us    <= dw_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/ignition_dwell_spark_scheduler.sv -----
// Tick, one-shot, stop and status go straight to the execute state; a start by advance first
// passes the multiply, divider-load and divider-run states, the last waiting on the 30-step
// bit-serial spark divider. One command at a time: the input reopens once the result sits in
// the output register, even while that beat still waits for the sink.
// Reset (synchronous, active low): all channels stopped and inactive, coils low, counters
// and times cleared, stored dwell 3000 us, no result pending.
module ignition_dwell_spark_scheduler #(
    parameter int CHANNELS     = 4,
    parameter int COUNTER_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  isd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output isd_pkg::t_out_item o_out_data
);
    import isd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    isd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    isd_dp #(
        .CHANNELS     (CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/isd_chk.sv -----
module isd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input isd_pkg::t_out_item o_out_data
);
    import isd_pkg::*;

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat pending after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // One command at a time: input closes after each accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted beat");

    // A coil can only be driven on an active channel
    a_coil_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.coil_levels & ~o_out_data.active_mask) == 4'd0))
        else $error("coil driven on an inactive channel");

    // Dwell never exceeds the low-speed, low-battery value
    a_dwell_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dwell_us <= DW_LO_0))
        else $error("dwell out of range");

endmodule

bind ignition_dwell_spark_scheduler isd_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
